### design/nts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nts_pkg
// Shared types, codes, tables and constant functions of the note tone
// sequencer.
// ----------------------------------------------------------------------------
package nts_pkg;

	// request kinds
	typedef enum logic {
		REQ_START = 1'b0,
		REQ_TICK  = 1'b1
	} req_kind_t;

	// configuration register indexes
	localparam logic [3:0] CFG_SAMPLES_PER_BEAT = 4'd0;
	localparam logic [3:0] CFG_REST_SAMPLES     = 4'd1;

	// input item
	typedef struct packed {
		req_kind_t   req_type;
		logic [3:0]  note_index;
		logic [3:0]  octave;
		logic [4:0]  duration_quarters;
	} req_t;

	// result item
	typedef struct packed {
		logic signed [15:0] sample;
		logic               in_rest;
		logic               note_done;
	} rsp_t;

	// command queue status seen by both sides
	typedef struct packed {
		logic full;
		logic nonempty;
	} q_status_t;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	localparam int          TONE_W    = 18;
	localparam logic [31:0] TONE_MAX  = 32'd262143;
	localparam int          REST_W    = 8;
	localparam logic [7:0]  NOTE_MAX  = 8'd11;
	localparam logic [3:0]  OCT_MAX   = 4'd8;
	localparam logic [15:0] SPB_RESET = 16'd22050;
	localparam logic [7:0]  REST_RESET = 8'd22;

	// sine series coefficients, Q30
	localparam logic [63:0] AMP     = 64'd32767;
	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] C_A1    = 64'd1686629713;
	localparam logic [63:0] C_A3    = 64'd693598669;
	localparam logic [63:0] C_A5    = 64'd85569306;
	localparam logic [63:0] C_A7    = 64'd5026995;
	localparam logic [63:0] C_A9    = 64'd172272;

	// octave-8 phase increments for 32 phase bits
	function automatic logic [31:0] oct8_inc(input logic [3:0] n);
		logic [31:0] v;
		unique case (n)
			4'd0:    v = 32'd407681904;
			4'd1:    v = 32'd431923931;
			4'd2:    v = 32'd457607465;
			4'd3:    v = 32'd484818220;
			4'd4:    v = 32'd513647012;
			4'd5:    v = 32'd544190053;
			4'd6:    v = 32'd576549277;
			4'd7:    v = 32'd610832681;
			4'd8:    v = 32'd647154683;
			4'd9:    v = 32'd685636503;
			4'd10:   v = 32'd726406571;
			4'd11:   v = 32'd769600953;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	// magnitude of sin(pi/2 * t), t in Q30; evaluated when building the table
	function automatic logic [15:0] quarter_sine(input logic [63:0] t);
		logic [63:0] t2;
		logic [63:0] p;
		logic [63:0] y;
		t2 = (t * t) >> 30;
		p  = C_A9;
		p  = C_A7 - ((t2 * p) >> 30);
		p  = C_A5 - ((t2 * p) >> 30);
		p  = C_A3 - ((t2 * p) >> 30);
		p  = C_A1 - ((t2 * p) >> 30);
		y  = (t * p) >> 30;
		y  = (y * AMP + (Q30_ONE >> 1)) >> 30;
		return (y > AMP) ? AMP[15:0] : y[15:0];
	endfunction

endpackage
`default_nettype wire

### design/nts_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nts_queue
// Short command queue between the front and the back of the sequencer.
// ----------------------------------------------------------------------------
module nts_queue
	import nts_pkg::*;
#(
	parameter int WIDTH = 59
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] head,
	output q_status_t             status
);

	logic [WIDTH-1:0] mem_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q;
	logic [Q_AW-1:0]  rd_ptr_q;
	logic [Q_AW:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full     = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign status.nonempty = (count_q != '0);
	assign do_push = push && !status.full;
	assign do_pop  = pop && status.nonempty;
	assign head    = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (!do_push && do_pop) count_q <= count_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

### design/nts_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nts_front
// Takes input items and register writes, screens start items and works out
// the phase increment and the tone length before queueing a command.
// ----------------------------------------------------------------------------
module nts_front
	import nts_pkg::*;
#(
	parameter int PHASE_BITS   = 32,
	parameter int MAX_QUARTERS = 16,
	localparam int EW = 1 + PHASE_BITS + TONE_W + REST_W
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	input  wire logic [3:0]    cfg_index,
	input  wire logic [15:0]   cfg_data,
	output logic               cfg_ready,
	input  wire logic          req_valid,
	input  wire req_t          req_item,
	output logic               req_stall,
	input  wire q_status_t     q_status,
	output logic               push,
	output logic      [EW-1:0] entry
);

	localparam int QW  = $clog2(MAX_QUARTERS + 1);
	localparam int SHL = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
	localparam int SHR = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;

	logic [15:0]           spb_q;
	logic [REST_W-1:0]     rest_cfg_q;
	logic [31:0]           base;
	logic [PHASE_BITS-1:0] inc_scaled;
	logic [PHASE_BITS-1:0] inc;
	logic [QW-1:0]         q_sat;
	logic [QW+15:0]        prod;
	logic [31:0]           tone_w;
	logic [TONE_W-1:0]     tone;
	logic                  is_tick;
	logic                  note_ok;

	assign cfg_ready = 1'b1;
	assign req_stall = q_status.full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spb_q      <= SPB_RESET;
			rest_cfg_q <= REST_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SAMPLES_PER_BEAT: spb_q      <= cfg_data;
				CFG_REST_SAMPLES:     rest_cfg_q <= cfg_data[REST_W-1:0];
				default: ;
			endcase
		end
	end

	// increment: table entry, rescaled to the phase width, down by octave
	always_comb begin
		base = oct8_inc(req_item.note_index);
		if (PHASE_BITS >= 32) inc_scaled = PHASE_BITS'(base) << SHL;
		else                  inc_scaled = PHASE_BITS'(base >> SHR);
		inc = inc_scaled >> (OCT_MAX - req_item.octave);
	end

	// tone length in samples, saturated
	always_comb begin
		if (32'(req_item.duration_quarters) > 32'(MAX_QUARTERS)) q_sat = QW'(MAX_QUARTERS);
		else q_sat = QW'(req_item.duration_quarters);
		prod   = (QW+16)'(q_sat) * (QW+16)'(spb_q);
		tone_w = 32'(prod) >> 2;
		tone   = (tone_w > TONE_MAX) ? '1 : tone_w[TONE_W-1:0];
	end

	// bad notes and octaves are dropped here; ticks always go through
	assign is_tick = (req_item.req_type == REQ_TICK);
	assign note_ok = (8'(req_item.note_index) <= NOTE_MAX) && (req_item.octave <= OCT_MAX);
	assign push    = req_valid && !q_status.full && (is_tick || note_ok);
	assign entry   = {is_tick, inc, tone, rest_cfg_q};

endmodule
`default_nettype wire

### design/nts_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nts_back
// Runs queued commands against the oscillator state: note loading, phase
// advance, tone and rest counting, sine lookup and the result register.
// ----------------------------------------------------------------------------
module nts_back
	import nts_pkg::*;
#(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10,
	localparam int EW = 1 + PHASE_BITS + TONE_W + REST_W
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [EW-1:0] head,
	input  wire q_status_t     q_status,
	output logic               pop,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output rsp_t               rsp_item
);

	localparam int STB     = SINE_TABLE_BITS;
	localparam int QB      = STB - 2;
	localparam int QUARTER = 1 << QB;

	typedef logic [15:0] qtab_t [QUARTER];

	function automatic qtab_t build_qtab();
		qtab_t tab;
		for (int i = 0; i < QUARTER; i++) begin
			tab[i] = quarter_sine(64'(i) << (30 - QB));
		end
		return tab;
	endfunction

	localparam qtab_t       QTAB = build_qtab();
	localparam logic [15:0] PEAK = quarter_sine(Q30_ONE);

	// head fields
	logic                  head_tick;
	logic [PHASE_BITS-1:0] head_inc;
	logic [TONE_W-1:0]     head_tone;
	logic [REST_W-1:0]     head_rest;

	// oscillator state
	logic [PHASE_BITS-1:0] phase_q, phase_n;
	logic [PHASE_BITS-1:0] inc_q, inc_n;
	logic [TONE_W-1:0]     tone_q, tone_n;
	logic [REST_W-1:0]     rest_q, rest_n;
	logic                  playing_q, playing_n;

	logic adv;
	logic hit;
	logic rest_flag;
	logic done;

	// stage 1: table address and flags
	logic           valid_s1;
	logic [STB-1:0] idx_s1;
	logic           rest_s1;
	logic           done_s1;

	// stage 2: result register
	logic rsp_valid_s2;
	rsp_t rsp_s2;

	logic [1:0]    quad;
	logic [QB-1:0] r;
	logic [QB-1:0] r_neg;
	logic [15:0]   mag;
	logic [15:0]   smp;

	assign head_tick = head[EW-1];
	assign head_inc  = head[EW-2 -: PHASE_BITS];
	assign head_tone = head[TONE_W+REST_W-1 -: TONE_W];
	assign head_rest = head[REST_W-1:0];

	// the whole back advances unless a result waits on a stalled receiver
	assign adv = !rsp_valid_s2 || !rsp_stall;
	assign pop = adv && q_status.nonempty;

	// command execution
	always_comb begin
		phase_n   = phase_q;
		inc_n     = inc_q;
		tone_n    = tone_q;
		rest_n    = rest_q;
		playing_n = playing_q;
		hit       = 1'b0;
		rest_flag = 1'b0;
		done      = 1'b0;
		if (pop) begin
			if (!head_tick) begin
				// start while busy is ignored
				if (!playing_q) begin
					inc_n     = head_inc;
					tone_n    = head_tone;
					rest_n    = head_rest;
					playing_n = (head_tone != '0) || (head_rest != '0);
				end
			end else if (playing_q) begin
				hit = 1'b1;
				if (tone_q != '0) begin
					phase_n = phase_q + inc_q;
					tone_n  = tone_q - 1'b1;
				end else begin
					rest_flag = 1'b1;
					if (rest_q != '0) rest_n = rest_q - 1'b1;
				end
				done = (tone_n == '0) && (rest_n == '0);
				if (done) playing_n = 1'b0;
			end
		end
	end

	// state and pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= '0;
			inc_q        <= '0;
			tone_q       <= '0;
			rest_q       <= '0;
			playing_q    <= 1'b0;
			valid_s1     <= 1'b0;
			rsp_valid_s2 <= 1'b0;
		end else begin
			phase_q   <= phase_n;
			inc_q     <= inc_n;
			tone_q    <= tone_n;
			rest_q    <= rest_n;
			playing_q <= playing_n;
			if (adv) begin
				valid_s1     <= hit;
				rsp_valid_s2 <= valid_s1;
			end
		end
	end

	// quarter-wave sine lookup
	always_comb begin
		quad  = idx_s1[STB-1 -: 2];
		r     = idx_s1[QB-1:0];
		r_neg = '0 - r;
		if (quad[0]) mag = (r == '0) ? PEAK : QTAB[r_neg];
		else         mag = QTAB[r];
		if (rest_s1)      smp = '0;
		else if (quad[1]) smp = 16'h0000 - mag;
		else              smp = mag;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1           <= phase_n[PHASE_BITS-1 -: STB];
			rest_s1          <= rest_flag;
			done_s1          <= done;
			rsp_s2.sample    <= smp;
			rsp_s2.in_rest   <= rest_s1;
			rsp_s2.note_done <= done_s1;
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign rsp_item  = rsp_s2;

	// a note ends only with its final sample entering the pipeline
	a_end_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(playing_q) |-> (valid_s1 && done_s1))
		else $error("note ended without a final sample");

	// a final sample leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s1) && done_s1 |-> !playing_q)
		else $error("final sample issued while still playing");

	// counts left over only while a note plays
	a_counts_busy: assert property (@(posedge clk) disable iff (!arst_n)
		((tone_q != '0) || (rest_q != '0)) |-> playing_q)
		else $error("samples left while idle");

	// no new result while a stalled one is held
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_s2 && rsp_stall |=> $stable(idx_s1) && $stable(valid_s1))
		else $error("stage 1 moved under a stall");

endmodule
`default_nettype wire

### design/note_tone_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// note_tone_sequencer
// Equal-tempered tone sequencer built on a numerically controlled oscillator.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req_item): start items and sample
//   ticks. A start item loads the note's increment and length; it gives no
//   result and is dropped when a note plays or its note/octave is invalid.
//   rsp channel (rsp_valid / rsp_stall / rsp_item): one item per tick while
//   a note plays: sine samples, then the rest zeros, the last one flagged.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
//   samples per beat, index 1 the rest length; write only while idle.
// Timing:
//   One item per cycle sustained while rsp_stall stays low. A tick's result
//   passes through the command queue, then the state update and sine
//   address stage, then the registered table lookup.
//   The four-entry queue lets the input side keep accepting while the
//   receiver stalls; req_stall rises once the queue is full.
// Reset: the phase, counters and queue clear, the block is idle, and the
//   registers return to 22050 samples per beat and 22 rest samples.
// ----------------------------------------------------------------------------
module note_tone_sequencer
	import nts_pkg::*;
#(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10,
	parameter int MAX_QUARTERS    = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire req_t        req_item,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output rsp_t             rsp_item
);

	localparam int EW = 1 + PHASE_BITS + TONE_W + REST_W;

	q_status_t      q_status;
	logic           push;
	logic           pop;
	logic [EW-1:0]  entry;
	logic [EW-1:0]  head;

	nts_front #(
		.PHASE_BITS   (PHASE_BITS),
		.MAX_QUARTERS (MAX_QUARTERS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.req_valid (req_valid),
		.req_item  (req_item),
		.req_stall (req_stall),
		.q_status  (q_status),
		.push      (push),
		.entry     (entry)
	);

	nts_queue #(
		.WIDTH (EW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (entry),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	nts_back #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

endmodule
`default_nettype wire

### bench/nts_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nts_checker
// Watches the request, result and register channels of the note tone
// sequencer, predicts each sample from its own oscillator model and compares
// every accepted result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module nts_checker
	import nts_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [3:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        req_valid,
	input  wire logic        req_stall,
	input  wire req_t        req_item,
	input  wire logic        rsp_valid,
	input  wire logic        rsp_stall,
	input  wire rsp_t        rsp_item,
	input  wire logic        end_of_test,
	output int               failures,
	output int               pending,
	output logic             busy,
	output int               effective,
	output int               notes_loaded,
	output int               samples_checked
);

	localparam int          LUT_BITS      = 10;
	localparam int          QUARTER_LEN   = 1 << (LUT_BITS - 2);
	localparam int          QUARTERS_CAP  = 16;
	localparam int unsigned TONE_CAP      = 262143;
	localparam logic [3:0]  NOTE_LAST     = 4'd11;
	localparam logic [3:0]  OCTAVE_LAST   = 4'd8;
	localparam logic [15:0] SPB_AT_RESET  = 16'd22050;
	localparam logic [7:0]  REST_AT_RESET = 8'd22;
	localparam int          REPORT_CAP    = 50;

	// Q30 series coefficients of sin(pi/2 * t)
	localparam logic [63:0] AMPLITUDE = 64'd32767;
	localparam logic [63:0] Q30       = 64'd1 << 30;
	localparam logic [63:0] K1        = 64'd1686629713;
	localparam logic [63:0] K3        = 64'd693598669;
	localparam logic [63:0] K5        = 64'd85569306;
	localparam logic [63:0] K7        = 64'd5026995;
	localparam logic [63:0] K9        = 64'd172272;

	logic [15:0] sine_lut [0:(1 << LUT_BITS) - 1];
	logic [31:0] oct8_step [0:11];

	// oscillator model state
	logic [15:0] beat_len;
	logic [7:0]  rest_len;
	logic [31:0] phase_acc;
	logic [31:0] phase_inc;
	logic [17:0] tone_left;
	logic [7:0]  rest_left;
	logic        playing;
	logic        leftovers_checked;
	rsp_t        sample_queue [$];

	task automatic report_mismatch(input string msg);
		if (failures < REPORT_CAP)
			$display("%0t mismatch: %s", $time, msg);
		failures++;
	endtask

	// sine table with quarter-wave symmetry, and the octave-8 increments
	initial begin : build_tables
		logic [63:0] r;
		logic [63:0] t;
		logic [63:0] t_sq;
		logic [63:0] acc;
		logic [63:0] y;
		logic [15:0] mag;
		int          quad;
		for (int i = 0; i < (1 << LUT_BITS); i++) begin
			quad = i / QUARTER_LEN;
			r    = 64'(i % QUARTER_LEN);
			if (quad % 2 == 1)
				r = 64'(QUARTER_LEN) - r;
			t    = r << (30 - (LUT_BITS - 2));
			t_sq = (t * t) >> 30;
			acc  = K9;
			acc  = K7 - ((t_sq * acc) >> 30);
			acc  = K5 - ((t_sq * acc) >> 30);
			acc  = K3 - ((t_sq * acc) >> 30);
			acc  = K1 - ((t_sq * acc) >> 30);
			y    = (t * acc) >> 30;
			y    = (y * AMPLITUDE + (Q30 >> 1)) >> 30;
			mag  = (y > AMPLITUDE) ? AMPLITUDE[15:0] : y[15:0];
			sine_lut[i] = (quad >= 2) ? (~mag + 16'd1) : mag;
		end
		oct8_step[0]  = 32'd407681904;
		oct8_step[1]  = 32'd431923931;
		oct8_step[2]  = 32'd457607465;
		oct8_step[3]  = 32'd484818220;
		oct8_step[4]  = 32'd513647012;
		oct8_step[5]  = 32'd544190053;
		oct8_step[6]  = 32'd576549277;
		oct8_step[7]  = 32'd610832681;
		oct8_step[8]  = 32'd647154683;
		oct8_step[9]  = 32'd685636503;
		oct8_step[10] = 32'd726406571;
		oct8_step[11] = 32'd769600953;
	end

	// channel monitor, predictor and comparison
	always @(posedge clk or negedge arst_n) begin : predict
		rsp_t        want;
		int unsigned quarters;
		int unsigned tone;
		if (!arst_n) begin
			beat_len          = SPB_AT_RESET;
			rest_len          = REST_AT_RESET;
			phase_acc         = '0;
			phase_inc         = '0;
			tone_left         = '0;
			rest_left         = '0;
			playing           = 1'b0;
			leftovers_checked = 1'b0;
			failures          = 0;
			effective         = 0;
			notes_loaded      = 0;
			samples_checked   = 0;
			sample_queue.delete();
		end else begin
			// compare an accepted result with the oldest prediction
			if (rsp_valid && !rsp_stall) begin
				if (sample_queue.size() == 0) begin
					report_mismatch($sformatf("result with none outstanding: sample %0d",
						rsp_item.sample));
				end else begin
					want = sample_queue.pop_front();
					samples_checked++;
					if (rsp_item.sample !== want.sample)
						report_mismatch($sformatf("sample got %0d want %0d",
							rsp_item.sample, want.sample));
					if (rsp_item.in_rest !== want.in_rest)
						report_mismatch($sformatf("in_rest got %0b want %0b",
							rsp_item.in_rest, want.in_rest));
					if (rsp_item.note_done !== want.note_done)
						report_mismatch($sformatf("note_done got %0b want %0b",
							rsp_item.note_done, want.note_done));
				end
			end

			// register writes
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SAMPLES_PER_BEAT)
					beat_len = cfg_data;
				else if (cfg_index == CFG_REST_SAMPLES)
					rest_len = cfg_data[7:0];
			end

			// accepted request
			if (req_valid && !req_stall) begin
				if (req_item.req_type == REQ_START) begin
					if (!playing && req_item.note_index <= NOTE_LAST &&
							req_item.octave <= OCTAVE_LAST) begin
						quarters = req_item.duration_quarters;
						if (quarters > QUARTERS_CAP)
							quarters = QUARTERS_CAP;
						tone = (quarters * int'(beat_len)) >> 2;
						if (tone > TONE_CAP)
							tone = TONE_CAP;
						phase_inc = oct8_step[req_item.note_index] >>
							(OCTAVE_LAST - req_item.octave);
						tone_left = 18'(tone);
						rest_left = rest_len;
						playing   = (tone_left != 0) || (rest_left != 0);
						effective++;
						notes_loaded++;
					end
				end else if (playing) begin
					if (tone_left != 0) begin
						phase_acc      = phase_acc + phase_inc;
						want.sample    = sine_lut[phase_acc[31 -: LUT_BITS]];
						want.in_rest   = 1'b0;
						tone_left      = tone_left - 18'd1;
					end else begin
						want.sample    = '0;
						want.in_rest   = 1'b1;
						if (rest_left != 0)
							rest_left = rest_left - 8'd1;
					end
					want.note_done = (tone_left == 0) && (rest_left == 0);
					if (want.note_done)
						playing = 1'b0;
					sample_queue.push_back(want);
					effective++;
				end
			end

			// anything still outstanding at the end is lost
			if (end_of_test && !leftovers_checked) begin
				leftovers_checked = 1'b1;
				if (sample_queue.size() != 0)
					report_mismatch($sformatf("%0d predicted samples never came",
						sample_queue.size()));
			end
		end
		pending = sample_queue.size();
		busy    = playing;
	end

endmodule

### bench/tb_note_tone_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_note_tone_sequencer
// Drives start items and sample ticks into the note tone sequencer under
// random idling on both channels, reprograms beat and rest lengths between
// phases, and leaves all checking to nts_checker.
// ----------------------------------------------------------------------------
module tb_note_tone_sequencer;
	import nts_pkg::*;

	localparam int         SETTLE_CYCLES    = 8;
	localparam int         LONG_HOLD_CYCLES = 60;
	localparam int         CYCLE_LIMIT      = 400000;
	localparam logic [3:0] CFG_SPARE_INDEX  = 4'd15;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        req_valid;
	logic        req_stall;
	req_t        req_item;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp_item;
	logic        end_of_test;

	int          failures;
	int          pending;
	logic        busy;
	int          effective;
	int          notes_loaded;
	int          samples_checked;

	logic        calm;
	int          hold_requests;
	int          holds_done;
	int          config_count;
	int          cycle_count;

	note_tone_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	nts_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req_item        (req_item),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.rsp_item        (rsp_item),
		.end_of_test     (end_of_test),
		.failures        (failures),
		.pending         (pending),
		.busy            (busy),
		.effective       (effective),
		.notes_loaded    (notes_loaded),
		.samples_checked (samples_checked)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d samples outstanding",
				cycle_count, pending);
			$display("FAIL");
			$finish;
		end
	end

	// result side: random stall per item, plus the long hold on request
	initial begin : result_sink
		int hold;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (holds_done < hold_requests) begin
				hold = LONG_HOLD_CYCLES;
				holds_done++;
			end else begin
				hold = calm ? 0 : $urandom_range(0, 14);
			end
			if (hold != 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	function automatic req_t start_item(input logic [3:0] note, input logic [3:0] oct,
			input logic [4:0] dur);
		req_t it;
		it.req_type          = REQ_START;
		it.note_index        = note;
		it.octave            = oct;
		it.duration_quarters = dur;
		return it;
	endfunction

	// tick with random content in the fields it does not use
	function automatic req_t tick_item();
		req_t it;
		it.req_type          = REQ_TICK;
		it.note_index        = 4'($urandom);
		it.octave            = 4'($urandom);
		it.duration_quarters = 5'($urandom);
		return it;
	endfunction

	// offer one item after a random gap; returns at the falling edge after
	// it was taken, with valid still high
	task automatic send_req(input req_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_item  <= it;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	// leaves cfg_valid high; the caller lowers it
	task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic finish_note();
		while (busy) send_req(tick_item());
	endtask

	task automatic configure(input logic [15:0] spb, input logic [7:0] rest);
		wait_drained();
		write_reg(CFG_SAMPLES_PER_BEAT, spb);
		write_reg(CFG_REST_SAMPLES, {8'($urandom), rest});
		cfg_valid <= 1'b0;
		config_count++;
	endtask

	// mostly well-formed notes with their ticks, some random noise items
	task automatic random_phase(input logic [15:0] spb, input logic [7:0] rest,
			input int target, input bit squeeze);
		int   goal;
		int   k;
		req_t it;
		configure(spb, rest);
		calm = 1'b0;
		if (squeeze) begin
			// long result hold while ticks keep coming: the queue must fill
			send_req(start_item(4'd7, 4'd5, 5'd16));
			hold_requests++;
			calm = 1'b1;
			for (k = 0; k < 40; k++)
				send_req(tick_item());
			calm = 1'b0;
		end
		goal = effective + target;
		while (effective < goal) begin
			if ($urandom_range(0, 63) == 0)
				calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < 12) begin
				it.req_type          = $urandom_range(0, 1) ? REQ_TICK : REQ_START;
				it.note_index        = 4'($urandom);
				it.octave            = 4'($urandom);
				it.duration_quarters = 5'($urandom);
			end else if (!busy) begin
				it = start_item(4'($urandom_range(0, 11)), 4'($urandom_range(0, 8)),
					($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
						: 5'($urandom_range(0, 16)));
			end else begin
				it = tick_item();
			end
			send_req(it);
		end
		calm = 1'b0;
		finish_note();
	endtask

	// stimulus
	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		req_valid     = 1'b0;
		req_item      = '0;
		end_of_test   = 1'b0;
		calm          = 1'b0;
		hold_requests = 0;
		holds_done    = 0;
		config_count  = 1;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// registers at reset: tick while idle, then a rest-only note
		send_req(start_item(4'd0, 4'd0, 5'd0) | req_t'({1'b1, 13'h1fff}));
		send_req(start_item(4'd9, 4'd4, 5'd0));
		finish_note();

		// directed: invalid notes, busy start, saturated length, empty note
		configure(16'd1, 8'd1);
		send_req(start_item(4'd12, 4'd4, 5'd4));
		send_req(start_item(4'd0, 4'd9, 5'd4));
		send_req(start_item(4'd15, 4'd15, 5'd31));
		send_req(start_item(4'd0, 4'd0, 5'd0));
		send_req(tick_item());
		send_req(start_item(4'd11, 4'd8, 5'd31));
		send_req(start_item(4'd3, 4'd2, 5'd8));
		finish_note();
		send_req(start_item(4'd11, 4'd0, 5'd8));
		finish_note();
		configure(16'd1, 8'd0);
		send_req(start_item(4'd0, 4'd0, 5'd3));
		send_req(tick_item());
		send_req(start_item(4'd5, 4'd3, 5'd16));
		finish_note();

		// random phases over a spread of beat and rest lengths
		random_phase(16'd1, 8'd0, 170, 1'b0);
		random_phase(16'd30, 8'd255, 170, 1'b1);
		random_phase(16'($urandom_range(2, 24)), 8'($urandom_range(0, 6)), 170, 1'b0);
		random_phase(16'd7, 8'd2, 170, 1'b0);
		random_phase(16'($urandom_range(1, 40)), 8'($urandom_range(0, 15)), 170, 1'b0);
		random_phase(16'd4, 8'd1, 170, 1'b0);

		// a write to an index with no register must leave both lengths alone
		configure(16'd3, 8'd2);
		wait_drained();
		write_reg(CFG_SPARE_INDEX, 16'($urandom));
		cfg_valid <= 1'b0;
		send_req(start_item(4'd2, 4'd6, 5'd16));
		finish_note();

		wait_drained();
		end_of_test <= 1'b1;
		repeat (2) @(negedge clk);
		$display("played %0d notes, %0d samples compared, %0d register configurations",
			notes_loaded, samples_checked, config_count);
		$display("including ignored starts, idle ticks and a full-queue stall");
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
